>>> design/rhs_pkg.sv
// shared types and helpers for the recursive halving schedule block
package rhs_pkg;

   localparam int MAX_NODES  = 256;
   localparam int RANK_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int STEP_W     = 3;
   localparam int LOG_W      = 4;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 4;

   localparam logic [1:0] ROLE_NORMAL = 2'd0;
   localparam logic [1:0] ROLE_RECV   = 2'd1;
   localparam logic [1:0] ROLE_SEND   = 2'd2;

   typedef struct packed {
      logic               err;
      logic [1:0]         role;
      logic [RANK_W-1:0]  nb;
      logic               single;
      logic [LOG_W-1:0]   k;
      logic [RANK_W-1:0]  g;
      logic [COUNT_W-1:0] b;
   } dec_type;

   typedef struct packed {
      logic               err;
      logic [1:0]         role;
      logic [RANK_W-1:0]  nb;
      logic               has_step;
      logic [STEP_W-1:0]  j;
      logic [RANK_W-1:0]  g;
      logic [RANK_W-1:0]  d;
      logic [COUNT_W-1:0] b;
      logic               last;
   } step_type;

   typedef struct packed {
      logic               err;
      logic [1:0]         role;
      logic [RANK_W-1:0]  nb;
      logic               has_step;
      logic [STEP_W-1:0]  j;
      logic               last;
      logic [RANK_W-1:0]  partner;
      logic [RANK_W-1:0]  rs;
      logic [COUNT_W-1:0] re;
      logic [RANK_W-1:0]  ss;
      logic [COUNT_W-1:0] se;
   } span_type;

   typedef struct packed {
      logic [1:0]         node_role;
      logic [RANK_W-1:0]  neighbour_rank;
      logic               has_step;
      logic [STEP_W-1:0]  step_index;
      logic [RANK_W-1:0]  partner_rank;
      logic [RANK_W-1:0]  send_start;
      logic [COUNT_W-1:0] send_length;
      logic [RANK_W-1:0]  recv_start;
      logic [COUNT_W-1:0] recv_length;
      logic               rank_error;
      logic               last;
   } res_type;

   // block start of a group: g below b maps to itself, else 2g - b
   function automatic logic [COUNT_W-1:0] block_start(input logic [COUNT_W-1:0] x,
                                                      input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] dbl;
      dbl = {x, 1'b0} - {1'b0, b};
      return (x < b) ? x : dbl[COUNT_W-1:0];
   endfunction

endpackage

>>> design/rhs_decode.sv
// first stage: clamps node count, finds group layout and role of the rank
module rhs_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rhs_pkg::RANK_W-1:0]    rank,
   input  logic [rhs_pkg::COUNT_W-1:0]   node_count,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rhs_pkg::dec_type              out_data
);

   logic                        valid_ff, valid_in;
   rhs_pkg::dec_type            data_ff, data_in;
   logic [rhs_pkg::COUNT_W-1:0] neff;
   logic [rhs_pkg::LOG_W-1:0]   k;
   logic [rhs_pkg::COUNT_W:0]   two_p;
   logic [rhs_pkg::COUNT_W:0]   b_wide;
   logic [rhs_pkg::COUNT_W-1:0] b;
   logic [rhs_pkg::COUNT_W-1:0] r9;
   logic [rhs_pkg::COUNT_W-1:0] off;
   logic [rhs_pkg::COUNT_W-1:0] g9;

   always_comb begin
      if (node_count == '0) begin
         neff = rhs_pkg::COUNT_W'(1);
      end else if (node_count > rhs_pkg::COUNT_W'(rhs_pkg::MAX_NODES)) begin
         neff = rhs_pkg::COUNT_W'(rhs_pkg::MAX_NODES);
      end else begin
         neff = node_count;
      end
      k = '0;
      for (int i = 0; i < rhs_pkg::COUNT_W; i++) begin
         if (neff[i]) begin
            k = rhs_pkg::LOG_W'(i);
         end
      end
      two_p  = (rhs_pkg::COUNT_W+1)'(2) << k;
      b_wide = two_p - {1'b0, neff};
      b      = b_wide[rhs_pkg::COUNT_W-1:0];
      r9     = {1'b0, rank};
      off    = r9 - b;
      g9     = b + {1'b0, off[rhs_pkg::COUNT_W-1:1]};

      data_in = data_ff;
      data_in.k = k;
      data_in.b = b;
      if (r9 >= neff) begin
         data_in.err    = 1'b1;
         data_in.role   = rhs_pkg::ROLE_NORMAL;
         data_in.nb     = '0;
         data_in.single = 1'b1;
         data_in.g      = '0;
      end else if (r9 < b) begin
         data_in.err    = 1'b0;
         data_in.role   = rhs_pkg::ROLE_NORMAL;
         data_in.nb     = '0;
         data_in.single = (k == '0);
         data_in.g      = rank;
      end else if (!off[0]) begin
         data_in.err    = 1'b0;
         data_in.role   = rhs_pkg::ROLE_RECV;
         data_in.nb     = rank + rhs_pkg::RANK_W'(1);
         data_in.single = (k == '0);
         data_in.g      = g9[rhs_pkg::RANK_W-1:0];
      end else begin
         data_in.err    = 1'b0;
         data_in.role   = rhs_pkg::ROLE_SEND;
         data_in.nb     = rank - rhs_pkg::RANK_W'(1);
         data_in.single = 1'b1;
         data_in.g      = '0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> design/rhs_expand.sv
// step sequencer: turns one decoded rank into its halving steps, one a cycle while the output is not stalled
module rhs_expand (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rhs_pkg::dec_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rhs_pkg::step_type    out_data
);

   logic                        item_valid_ff, item_valid_in;
   rhs_pkg::dec_type            item_ff;
   logic [rhs_pkg::STEP_W-1:0]  j_ff, j_in;
   logic                        out_valid_ff, out_valid_in;
   rhs_pkg::step_type           out_ff, out_in;
   logic                        stage_ready;
   logic                        emit;
   logic                        item_last;
   logic [rhs_pkg::LOG_W-1:0]   shift;
   logic                        load;

   assign stage_ready = !out_valid_ff || out_ready;
   assign emit        = item_valid_ff && stage_ready;
   assign item_last   = item_ff.single ||
                        (({1'b0, j_ff} + rhs_pkg::LOG_W'(1)) == item_ff.k);
   assign in_ready    = !item_valid_ff || (stage_ready && item_last);
   assign load        = in_ready && in_valid;
   assign shift       = item_ff.k - rhs_pkg::LOG_W'(1) - {1'b0, j_ff};

   always_comb begin
      out_in          = out_ff;
      out_in.err      = item_ff.err;
      out_in.role     = item_ff.role;
      out_in.nb       = item_ff.nb;
      out_in.has_step = !item_ff.single;
      out_in.j        = j_ff;
      out_in.g        = item_ff.g;
      out_in.d        = rhs_pkg::RANK_W'(1) << shift;
      out_in.b        = item_ff.b;
      out_in.last     = item_last;

      item_valid_in = in_ready ? in_valid : item_valid_ff;
      if (load) begin
         j_in = '0;
      end else if (emit) begin
         j_in = j_ff + rhs_pkg::STEP_W'(1);
      end else begin
         j_in = j_ff;
      end
      out_valid_in = stage_ready ? item_valid_ff : out_valid_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         j_ff          <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
         j_ff          <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_data;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> design/rhs_span.sv
// span stages: block starts of both spans, then lengths into the result register
module rhs_span (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rhs_pkg::step_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rhs_pkg::res_type     out_data
);

   logic                        span_valid_ff, span_valid_in;
   rhs_pkg::span_type           span_ff, span_in;
   logic                        res_valid_ff, res_valid_in;
   rhs_pkg::res_type            res_ff, res_in;
   logic                        res_ready;
   logic [rhs_pkg::RANK_W-1:0]  pg;
   logic [rhs_pkg::RANK_W-1:0]  mask;
   logic [rhs_pkg::RANK_W-1:0]  rb;
   logic [rhs_pkg::RANK_W-1:0]  sb;
   logic [rhs_pkg::COUNT_W-1:0] rs9;
   logic [rhs_pkg::COUNT_W-1:0] ss9;
   logic [rhs_pkg::COUNT_W-1:0] pr9;

   assign res_ready = !res_valid_ff || out_ready;
   assign in_ready  = !span_valid_ff || res_ready;

   always_comb begin
      pg   = in_data.g ^ in_data.d;
      mask = ~(in_data.d - rhs_pkg::RANK_W'(1));
      rb   = in_data.g & mask;
      sb   = pg & mask;
      rs9  = rhs_pkg::block_start({1'b0, rb}, in_data.b);
      ss9  = rhs_pkg::block_start({1'b0, sb}, in_data.b);
      pr9  = rhs_pkg::block_start({1'b0, pg}, in_data.b);

      span_in          = span_ff;
      span_in.err      = in_data.err;
      span_in.role     = in_data.role;
      span_in.nb       = in_data.nb;
      span_in.has_step = in_data.has_step;
      span_in.j        = in_data.j;
      span_in.last     = in_data.last;
      span_in.partner  = pr9[rhs_pkg::RANK_W-1:0];
      span_in.rs       = rs9[rhs_pkg::RANK_W-1:0];
      span_in.re       = rhs_pkg::block_start({1'b0, rb} + {1'b0, in_data.d}, in_data.b);
      span_in.ss       = ss9[rhs_pkg::RANK_W-1:0];
      span_in.se       = rhs_pkg::block_start({1'b0, sb} + {1'b0, in_data.d}, in_data.b);

      res_in                = res_ff;
      res_in.node_role      = span_ff.role;
      res_in.neighbour_rank = span_ff.nb;
      res_in.has_step       = span_ff.has_step;
      res_in.rank_error     = span_ff.err;
      res_in.last           = span_ff.last;
      if (span_ff.has_step) begin
         res_in.step_index   = span_ff.j;
         res_in.partner_rank = span_ff.partner;
         res_in.send_start   = span_ff.ss;
         res_in.send_length  = span_ff.se - {1'b0, span_ff.ss};
         res_in.recv_start   = span_ff.rs;
         res_in.recv_length  = span_ff.re - {1'b0, span_ff.rs};
      end else begin
         res_in.step_index   = '0;
         res_in.partner_rank = '0;
         res_in.send_start   = '0;
         res_in.send_length  = '0;
         res_in.recv_start   = '0;
         res_in.recv_length  = '0;
      end

      span_valid_in = in_ready ? in_valid : span_valid_ff;
      res_valid_in  = res_ready ? span_valid_ff : res_valid_ff;
   end

   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         span_valid_ff <= span_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         span_ff <= span_in;
      end
      if (res_ready && span_valid_ff) begin
         res_ff <= res_in;
      end
   end

endmodule

>>> design/recursive_halving_schedule.sv
// a request's first result passes the decode, item, step, span and result registers to rsp
// output: one result per cycle unless rsp stalls; a request with steps gives k results, with
// k = floor(log2(node_count)), up to 8, set by the step sequencer in rhs_expand
// a request ends in one result when the rank is out of range, a sending member or alone
// reset clears all pipeline valids and sets node_count to 1
module recursive_halving_schedule (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // rank
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // neighbour_rank, step_index, partner_rank, send_start, send_length,
   // recv_start, recv_length, zero pad
   output logic [rhs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [rhs_pkg::RSP_USER_W-1:0]    rsp_tuser,   // node_role, has_step, rank_error
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rhs_pkg::COUNT_W-1:0]       csr_data     // node_count
);

   logic [rhs_pkg::COUNT_W-1:0] node_count_ff;
   logic                        dec_valid, dec_ready;
   rhs_pkg::dec_type            dec_data;
   logic                        step_valid, step_ready;
   rhs_pkg::step_type           step_data;
   rhs_pkg::res_type            res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= rhs_pkg::COUNT_W'(1);
      end else if (csr_valid) begin
         node_count_ff <= csr_data;
      end
   end

   rhs_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .rank       (req_tdata),
      .node_count (node_count_ff),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   rhs_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_data  (step_data)
   );

   rhs_span u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_data   (step_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {3'b000, res.recv_length, res.recv_start, res.send_length,
                       res.send_start, res.partner_rank, res.step_index,
                       res.neighbour_rank};
   assign rsp_tuser = {res.rank_error, res.has_step, res.node_role};
   assign rsp_tlast = res.last;

endmodule

>>> verif/tb_recursive_halving_schedule.sv
// self-checking testbench for the recursive halving schedule block
module tb_recursive_halving_schedule;
   timeunit 1ns;
   timeprecision 1ps;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [rhs_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic [rhs_pkg::RSP_USER_W-1:0]    rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [rhs_pkg::COUNT_W-1:0]       csr_data   = '0;

   logic [7:0]                        rank_q[$];
   rhs_pkg::res_type                  schedule_q[$];
   logic [rhs_pkg::COUNT_W-1:0]       node_count_cfg = 9'd1;
   int unsigned                       send_idle_pct  = 0;
   int unsigned                       recv_idle_pct  = 0;
   int unsigned                       mismatches     = 0;
   int unsigned                       corner_counts[8] = '{0, 1, 2, 3, 255, 256, 257, 511};

   recursive_halving_schedule u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned effective_count();
      int unsigned n;
      n = 32'(node_count_cfg);
      if (n == 0) n = 1;
      if (n > rhs_pkg::MAX_NODES) n = rhs_pkg::MAX_NODES;
      return n;
   endfunction

   function automatic int unsigned group_block(int unsigned grp, int unsigned folded);
      return (grp < folded) ? grp : 2 * grp - folded;
   endfunction

   function automatic void expect_result(rhs_pkg::res_type r);
      schedule_q = {schedule_q, r};
   endfunction

   // expands one rank into its step results at the current node count
   function automatic void predict_schedule(logic [7:0] rank);
      int unsigned      n, k, p, b, g, d, pg, rb, sb, rs, ss, j;
      logic [1:0]       role;
      logic [7:0]       nb;
      rhs_pkg::res_type r;
      n = effective_count();
      r = '0;
      if (rank >= n) begin
         r.rank_error = 1'b1;
         r.last       = 1'b1;
         expect_result(r);
         return;
      end
      k = 0;
      while ((2 << k) <= n) k++;
      p = 1 << k;
      b = 2 * p - n;
      if (rank < b) begin
         g    = 32'(rank);
         role = rhs_pkg::ROLE_NORMAL;
         nb   = '0;
      end else if (((rank - b) & 1) == 0) begin
         g    = b + ((rank - b) >> 1);
         role = rhs_pkg::ROLE_RECV;
         nb   = rank + 8'd1;
      end else begin
         r.node_role      = rhs_pkg::ROLE_SEND;
         r.neighbour_rank = rank - 8'd1;
         r.last           = 1'b1;
         expect_result(r);
         return;
      end
      if (k == 0) begin
         r.node_role      = role;
         r.neighbour_rank = nb;
         r.last           = 1'b1;
         expect_result(r);
         return;
      end
      for (j = 0; j < k && j < 8; j++) begin
         d  = p >> (j + 1);
         pg = g ^ d;
         rb = (g / d) * d;
         sb = (pg / d) * d;
         rs = group_block(rb, b);
         ss = group_block(sb, b);
         r                = '0;
         r.node_role      = role;
         r.neighbour_rank = nb;
         r.has_step       = 1'b1;
         r.step_index     = j[rhs_pkg::STEP_W-1:0];
         r.partner_rank   = 8'(group_block(pg, b));
         r.send_start     = 8'(ss);
         r.send_length    = 9'(group_block(sb + d, b) - ss);
         r.recv_start     = 8'(rs);
         r.recv_length    = 9'(group_block(rb + d, b) - rs);
         r.last           = (j + 1 == k);
         expect_result(r);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_schedule(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (rank_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rank_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_stall
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      rhs_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (schedule_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual tdata=%h tuser=%h tlast=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = schedule_q.pop_front();
            check_field("neighbour_rank", want.neighbour_rank, rsp_tdata[7:0]);
            check_field("step_index",     want.step_index,     rsp_tdata[10:8]);
            check_field("partner_rank",   want.partner_rank,   rsp_tdata[18:11]);
            check_field("send_start",     want.send_start,     rsp_tdata[26:19]);
            check_field("send_length",    want.send_length,    rsp_tdata[35:27]);
            check_field("recv_start",     want.recv_start,     rsp_tdata[43:36]);
            check_field("recv_length",    want.recv_length,    rsp_tdata[52:44]);
            check_field("node_role",      want.node_role,      rsp_tuser[1:0]);
            check_field("has_step",       want.has_step,       rsp_tuser[2]);
            check_field("rank_error",     want.rank_error,     rsp_tuser[3]);
            check_field("last",           want.last,           rsp_tlast);
         end
      end
   end

   // wait until no request is queued, in flight or owed a result
   task automatic settle();
      do @(negedge clock);
      while (rank_q.size() != 0 || req_tvalid || schedule_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_node_count(logic [rhs_pkg::COUNT_W-1:0] value);
      settle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      node_count_cfg = value;
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset count of one, then the corners of folding and saturation
      rank_q = '{8'd0, 8'd1, 8'd255};
      set_node_count(9'd0);
      rank_q = '{8'd0, 8'd200};
      set_node_count(9'd6);
      rank_q = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
      set_node_count(9'd256);
      rank_q = '{8'd0, 8'd128, 8'd170, 8'd255};
      set_node_count(9'd257);
      rank_q = '{8'd255};
      set_node_count(9'd511);
      rank_q = '{8'd85};
      set_node_count(9'd255);
      rank_q = '{8'd0, 8'd253, 8'd254, 8'd255};
      set_node_count(9'd3);
      rank_q = '{8'd0, 8'd1, 8'd2};

      for (int ph = 0; ph < 3; ph++) begin
         for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(0, 3))
               0:       set_node_count(9'(corner_counts[$urandom_range(0, 7)]));
               1:       set_node_count(9'($urandom_range(0, 511)));
               default: set_node_count(9'($urandom_range(2, 256)));
            endcase
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 28 : 0;
            n = effective_count();
            for (int i = 0; i < 25; i++) begin
               if ($urandom_range(0, 9) < 8)
                  rank_q = {rank_q, 8'($urandom_range(0, n - 1))};
               else
                  rank_q = {rank_q, 8'($urandom_range(0, 255))};
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && schedule_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
